// ===== rtl/pcbv_pkg.sv =====
// Package for the pcapng block chain validator.
// Block type codes, byte-order magic, status codes, state and result types.
// No dependencies.
package pcbv_pkg;

    localparam int OFFSET_BITS = 48;

    localparam logic [31:0] T_SECTION = 32'h0A0D0D0A;
    localparam logic [31:0] T_IFACE   = 32'h00000001;
    localparam logic [31:0] T_EPB     = 32'h00000006;
    localparam logic [31:0] T_SPB     = 32'h00000003;
    localparam logic [31:0] T_NRB     = 32'h00000004;
    localparam logic [31:0] BO_MAGIC  = 32'h1A2B3C4D;
    localparam logic [31:0] MIN_LEN   = 32'd12;
    localparam logic [31:0] LEN_ALIGN = 32'h00000003;

    localparam logic [31:0] IDX_TYPE_END  = 32'd3;
    localparam logic [31:0] IDX_LEN_END   = 32'd7;
    localparam logic [31:0] IDX_MAGIC_END = 32'd11;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;
    localparam logic [31:0] COUNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_MATCHED  = 2'd0,
        ST_NOMATCH  = 2'd1,
        ST_NEEDMORE = 2'd2,
        ST_PARTIAL  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        MAGIC_BAD    = 2'd0,
        MAGIC_LITTLE = 2'd1,
        MAGIC_BIG    = 2'd2
    } magic_t;

    typedef struct packed {
        logic                   active;
        logic [31:0]            byte_in_block;
        logic [31:0]            block_length;
        logic [31:0]            block_type;
        logic [31:0]            word_shift;
        logic                   byte_order;
        logic [OFFSET_BITS-1:0] block_start;
        logic [OFFSET_BITS-1:0] current_offset;
        logic                   any_done;
        logic [31:0]            sections;
        logic [31:0]            ifaces;
        logic [31:0]            packets;
        magic_t                 magic_code;
    } state_t;

    typedef struct packed {
        logic                   fire;
        status_t                status;
        logic [OFFSET_BITS-1:0] matched_length;
        logic                   big_endian;
        logic [31:0]            sections;
        logic [31:0]            ifaces;
        logic [31:0]            packets;
    } result_t;

    function automatic logic [31:0] swap32(input logic [31:0] x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic logic [31:0] decode(input logic [31:0] raw, input logic big);
        return big ? swap32(raw) : raw;
    endfunction

    function automatic logic known_type(input logic [31:0] t);
        return (t == T_SECTION) || (t == T_IFACE) || (t == T_EPB)
            || (t == T_SPB) || (t == T_NRB);
    endfunction

    function automatic logic [31:0] sat_inc32(input logic [31:0] v);
        return (v == COUNT_MAX) ? v : v + 32'd1;
    endfunction

endpackage

// ===== rtl/pcbv_if.sv =====
// Channel interfaces of the pcapng block chain validator: byte beats in,
// verdict beats out. Depends on pcbv_pkg for the offset width.
interface pcbv_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first;
    logic       last;
    logic       final_chunk;

    modport source (output valid, data_byte, first, last, final_chunk, input ready);
    modport sink (input valid, data_byte, first, last, final_chunk, output ready);
endinterface

interface pcbv_out_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      status;
    logic [pcbv_pkg::OFFSET_BITS-1:0] matched_length;
    logic                            big_endian;
    logic [31:0]                     section_count;
    logic [31:0]                     interface_count;
    logic [31:0]                     packet_count;

    modport source (output valid, status, matched_length, big_endian, section_count,
                    interface_count, packet_count, input ready);
    modport sink (input valid, status, matched_length, big_endian, section_count,
                  interface_count, packet_count, output ready);
endinterface

// ===== rtl/pcbv_step.sv =====
// Next-state and verdict logic for one byte of the pcapng block chain.
// Depends on pcbv_pkg (state_t, result_t, block codes, decode helpers).
module pcbv_step (
    input  pcbv_pkg::state_t  cur,
    input  logic [7:0]        data_byte,
    input  logic              first,
    input  logic              last,
    input  logic              final_chunk,
    output pcbv_pkg::state_t  nxt,
    output pcbv_pkg::result_t res
);

    pcbv_pkg::state_t               s;
    logic [31:0]                    i;
    logic                           emit;
    pcbv_pkg::status_t              st;
    logic [pcbv_pkg::OFFSET_BITS-1:0] len;
    pcbv_pkg::magic_t               code;
    logic [31:0]                    trail;

    always_comb
    begin
        s     = cur;
        emit  = 1'b0;
        st    = pcbv_pkg::ST_MATCHED;
        len   = '0;
        code  = pcbv_pkg::MAGIC_BAD;
        i     = '0;
        trail = '0;

        if (first)
        begin
            s        = '0;
            s.active = 1'b1;
        end

        if (s.active)
        begin
            i               = s.byte_in_block;
            s.byte_in_block = i + 32'd1;
            s.word_shift    = {data_byte, s.word_shift[31:8]};
            if (s.current_offset != pcbv_pkg::OFFSET_MAX)
            begin
                s.current_offset = s.current_offset
                                 + {{(pcbv_pkg::OFFSET_BITS-1){1'b0}}, 1'b1};
            end

            case (i)
                pcbv_pkg::IDX_TYPE_END:
                begin
                    s.block_type = pcbv_pkg::decode(s.word_shift, s.byte_order);
                    if (s.any_done && !pcbv_pkg::known_type(s.block_type))
                    begin
                        emit = 1'b1;
                        st   = pcbv_pkg::ST_MATCHED;
                        len  = s.block_start;
                    end
                end
                pcbv_pkg::IDX_LEN_END:
                begin
                    s.block_length = s.word_shift;
                end
                pcbv_pkg::IDX_MAGIC_END:
                begin
                    if (s.word_shift == pcbv_pkg::BO_MAGIC)
                    begin
                        code = pcbv_pkg::MAGIC_LITTLE;
                    end
                    else if (pcbv_pkg::swap32(s.word_shift) == pcbv_pkg::BO_MAGIC)
                    begin
                        code = pcbv_pkg::MAGIC_BIG;
                    end
                    if (!s.any_done)
                    begin
                        if (s.block_type != pcbv_pkg::T_SECTION
                            || code == pcbv_pkg::MAGIC_BAD)
                        begin
                            emit = 1'b1;
                            st   = pcbv_pkg::ST_NOMATCH;
                        end
                        else
                        begin
                            s.byte_order = (code == pcbv_pkg::MAGIC_BIG);
                        end
                    end
                    else
                    begin
                        s.magic_code = code;
                    end
                    if (!emit)
                    begin
                        s.block_length = pcbv_pkg::decode(s.block_length, s.byte_order);
                        if (s.block_length < pcbv_pkg::MIN_LEN
                            || (s.block_length & pcbv_pkg::LEN_ALIGN) != 32'd0)
                        begin
                            emit = 1'b1;
                            st   = s.any_done ? pcbv_pkg::ST_MATCHED : pcbv_pkg::ST_NOMATCH;
                            len  = s.block_start;
                        end
                    end
                end
                default:
                begin
                end
            endcase

            if (!emit && i >= pcbv_pkg::IDX_MAGIC_END && i == s.block_length - 32'd1)
            begin
                trail = pcbv_pkg::decode(s.word_shift, s.byte_order);
                if (trail != s.block_length)
                begin
                    emit = 1'b1;
                    st   = s.any_done ? pcbv_pkg::ST_MATCHED : pcbv_pkg::ST_NOMATCH;
                    len  = s.block_start;
                end
                else
                begin
                    if (s.block_type == pcbv_pkg::T_SECTION)
                    begin
                        s.sections = pcbv_pkg::sat_inc32(s.sections);
                    end
                    else if (s.block_type == pcbv_pkg::T_IFACE)
                    begin
                        s.ifaces = pcbv_pkg::sat_inc32(s.ifaces);
                    end
                    else if (s.block_type == pcbv_pkg::T_EPB
                             || s.block_type == pcbv_pkg::T_SPB)
                    begin
                        s.packets = pcbv_pkg::sat_inc32(s.packets);
                    end
                    if (s.block_type == pcbv_pkg::T_SECTION && s.any_done)
                    begin
                        if (s.magic_code == pcbv_pkg::MAGIC_BAD)
                        begin
                            emit = 1'b1;
                            st   = pcbv_pkg::ST_MATCHED;
                            len  = s.block_start;
                        end
                        else
                        begin
                            s.byte_order = (s.magic_code == pcbv_pkg::MAGIC_BIG);
                        end
                    end
                    if (!emit)
                    begin
                        s.any_done      = 1'b1;
                        s.block_start   = s.current_offset;
                        s.byte_in_block = '0;
                        s.word_shift    = '0;
                        if (last)
                        begin
                            emit = 1'b1;
                            st   = final_chunk ? pcbv_pkg::ST_MATCHED : pcbv_pkg::ST_NEEDMORE;
                            len  = s.current_offset;
                        end
                    end
                end
            end

            if (!emit && last)
            begin
                emit = 1'b1;
                st   = final_chunk ? pcbv_pkg::ST_PARTIAL : pcbv_pkg::ST_NEEDMORE;
            end

            if (emit)
            begin
                s.active = 1'b0;
            end
        end

        nxt                = s;
        res.fire           = emit;
        res.status         = st;
        res.matched_length = (st == pcbv_pkg::ST_MATCHED) ? len : '0;
        res.big_endian     = s.byte_order;
        res.sections       = s.sections;
        res.ifaces         = s.ifaces;
        res.packets        = s.packets;
    end

endmodule

// ===== rtl/pcapng_block_chain_validator.sv =====
// Top level of the pcapng block chain validator: input beat register, parse
// state, step logic and output verdict register. Depends on pcbv_pkg, pcbv_if
// and pcbv_step.
//
// Usage:
//   stream carries one buffer byte per beat with first, last and final_chunk.
//   A beat with first set starts a new parse at offset 0; bytes without a
//   running parse are dropped with no verdict.
//   result carries at most one verdict beat per parse: status, matched length, byte
//   order in effect and the section, interface and packet counts.
//   Throughput is one byte per cycle while result is not stalled, set by
//   the combinational step logic between the input beat register and the
//   parse state. The deciding byte passes from the input register through
//   the step logic into the verdict register, which drives result.valid.
//   When result stalls with a verdict held, the next byte waits in the input
//   register and stream.ready drops until the verdict is taken.
//   Reset clears the parse state and both valid flags; the block then waits
//   for a byte marked first.
module pcapng_block_chain_validator (
    input  logic       clk,
    input  logic       rst_n,
    pcbv_in_if.sink    stream,
    pcbv_out_if.source result
);

    logic              in_valid_reg;
    logic [7:0]        data_byte_reg;
    logic              first_reg;
    logic              last_reg;
    logic              final_chunk_reg;

    pcbv_pkg::state_t  state_reg;
    pcbv_pkg::state_t  state_next;
    pcbv_pkg::result_t step_res;

    logic              out_valid_reg;
    pcbv_pkg::result_t out_reg;

    logic              step_fire;
    logic              in_fire;

    assign step_fire    = in_valid_reg && (!out_valid_reg || result.ready);
    assign stream.ready = !in_valid_reg || step_fire;
    assign in_fire      = stream.valid && stream.ready;

    pcbv_step u_step (
        .cur         (state_reg),
        .data_byte   (data_byte_reg),
        .first       (first_reg),
        .last        (last_reg),
        .final_chunk (final_chunk_reg),
        .nxt         (state_next),
        .res         (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (step_fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (step_fire)
            begin
                state_reg <= state_next;
            end

            if (step_fire && step_res.fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            data_byte_reg   <= stream.data_byte;
            first_reg       <= stream.first;
            last_reg        <= stream.last;
            final_chunk_reg <= stream.final_chunk;
        end
        if (step_fire && step_res.fire)
        begin
            out_reg <= step_res;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.status          = out_reg.status;
    assign result.matched_length  = out_reg.matched_length;
    assign result.big_endian      = out_reg.big_endian;
    assign result.section_count   = out_reg.sections;
    assign result.interface_count = out_reg.ifaces;
    assign result.packet_count    = out_reg.packets;

endmodule

// ===== tb/tb_pcapng_block_chain_validator.sv =====
// Self-checking testbench for pcapng_block_chain_validator: random and directed
// pcapng byte streams, a behavioral verdict predictor and an in-order scoreboard.
// Depends on pcbv_pkg, pcbv_if and the validator RTL.
module tb_pcapng_block_chain_validator;
    import pcbv_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
        logic       last;
        logic       final_chunk;
        logic       pause;
    } beat_t;

    typedef struct packed {
        status_t                status;
        logic [OFFSET_BITS-1:0] matched;
        logic                   big;
        logic [31:0]            sections;
        logic [31:0]            ifaces;
        logic [31:0]            packets;
    } verdict_t;

    typedef enum int {
        FAULT_NONE,
        FAULT_TYPE,
        FAULT_MAGIC,
        FAULT_LEN,
        FAULT_TRAIL,
        FAULT_ORDER
    } fault_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    pcbv_in_if  stream_bus ();
    pcbv_out_if result_bus ();

    pcapng_block_chain_validator DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .stream (stream_bus),
        .result (result_bus)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    beat_t      pending[$];
    beat_t      on_wire;
    verdict_t   verdicts_due[$];
    logic [7:0] image[$];
    int         blk_marks[$];

    int beats_total = 0;
    int beats_accepted = 0;
    int chain_items = 0;
    int captures = 0;
    int fails = 0;
    int verdicts_seen = 0;
    int tally[4];

    wire steady = (beats_accepted >= 300) && (beats_accepted < 650);

    // predictor state
    logic                   parsing;
    logic [31:0]            blk_pos;
    logic [31:0]            blk_len;
    logic [31:0]            blk_type;
    logic [31:0]            tail_word;
    logic                   big_order;
    logic [OFFSET_BITS-1:0] blk_start;
    logic [OFFSET_BITS-1:0] cur_off;
    logic                   chain_open;
    logic [31:0]            n_sections;
    logic [31:0]            n_ifaces;
    logic [31:0]            n_packets;
    magic_t                 shb_magic;

    function automatic logic [31:0] flip_bytes(input logic [31:0] w);
        return {w[7:0], w[15:8], w[23:16], w[31:24]};
    endfunction

    function automatic logic [31:0] in_order(input logic [31:0] w);
        return big_order ? flip_bytes(w) : w;
    endfunction

    function automatic logic listed_type(input logic [31:0] t);
        case (t)
            T_SECTION, T_IFACE, T_EPB, T_SPB, T_NRB: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    task automatic forget_state();
        blk_pos = '0;
        blk_len = '0;
        blk_type = '0;
        tail_word = '0;
        big_order = 1'b0;
        blk_start = '0;
        cur_off = '0;
        chain_open = 1'b0;
        n_sections = '0;
        n_ifaces = '0;
        n_packets = '0;
        shb_magic = MAGIC_BAD;
    endtask

    task automatic track_beat(input beat_t bt);
        logic [31:0]            idx;
        logic [31:0]            w;
        magic_t                 code;
        logic                   decided;
        status_t                st;
        logic [OFFSET_BITS-1:0] span;
        verdict_t               v;
        decided = 1'b0;
        st = ST_MATCHED;
        span = '0;
        if (bt.first)
        begin
            forget_state();
            parsing = 1'b1;
        end
        if (!parsing)
            return;
        idx = blk_pos;
        blk_pos = idx + 32'd1;
        tail_word = {bt.data_byte, tail_word[31:8]};
        if (cur_off != OFFSET_MAX)
            cur_off = cur_off + {{(OFFSET_BITS-1){1'b0}}, 1'b1};

        if (idx == IDX_TYPE_END)
        begin
            blk_type = in_order(tail_word);
            if (chain_open && !listed_type(blk_type))
            begin
                decided = 1'b1;
                st = ST_MATCHED;
                span = blk_start;
            end
        end
        else if (idx == IDX_LEN_END)
            blk_len = tail_word;
        else if (idx == IDX_MAGIC_END)
        begin
            w = tail_word;
            if (w == BO_MAGIC)
                code = MAGIC_LITTLE;
            else if (flip_bytes(w) == BO_MAGIC)
                code = MAGIC_BIG;
            else
                code = MAGIC_BAD;
            if (!chain_open)
            begin
                if (blk_type != T_SECTION || code == MAGIC_BAD)
                begin
                    decided = 1'b1;
                    st = ST_NOMATCH;
                end
                else
                    big_order = (code == MAGIC_BIG);
            end
            else
                shb_magic = code;
            if (!decided)
            begin
                blk_len = in_order(blk_len);
                if (blk_len < MIN_LEN || (blk_len & LEN_ALIGN) != '0)
                begin
                    decided = 1'b1;
                    st = chain_open ? ST_MATCHED : ST_NOMATCH;
                    span = blk_start;
                end
            end
        end

        if (!decided && idx >= IDX_MAGIC_END && idx == blk_len - 32'd1)
        begin
            if (in_order(tail_word) != blk_len)
            begin
                decided = 1'b1;
                st = chain_open ? ST_MATCHED : ST_NOMATCH;
                span = blk_start;
            end
            else
            begin
                if (blk_type == T_SECTION)
                begin
                    if (n_sections != COUNT_MAX)
                        n_sections = n_sections + 32'd1;
                end
                else if (blk_type == T_IFACE)
                begin
                    if (n_ifaces != COUNT_MAX)
                        n_ifaces = n_ifaces + 32'd1;
                end
                else if (blk_type == T_EPB || blk_type == T_SPB)
                begin
                    if (n_packets != COUNT_MAX)
                        n_packets = n_packets + 32'd1;
                end
                if (blk_type == T_SECTION && chain_open)
                begin
                    if (shb_magic == MAGIC_BAD)
                    begin
                        decided = 1'b1;
                        st = ST_MATCHED;
                        span = blk_start;
                    end
                    else
                        big_order = (shb_magic == MAGIC_BIG);
                end
                if (!decided)
                begin
                    chain_open = 1'b1;
                    blk_start = cur_off;
                    blk_pos = '0;
                    tail_word = '0;
                    if (bt.last)
                    begin
                        decided = 1'b1;
                        st = bt.final_chunk ? ST_MATCHED : ST_NEEDMORE;
                        span = cur_off;
                    end
                end
            end
        end

        if (!decided && bt.last)
        begin
            decided = 1'b1;
            st = bt.final_chunk ? ST_PARTIAL : ST_NEEDMORE;
        end
        if (decided)
        begin
            parsing = 1'b0;
            v.status = st;
            v.matched = (st == ST_MATCHED) ? span : '0;
            v.big = big_order;
            v.sections = n_sections;
            v.ifaces = n_ifaces;
            v.packets = n_packets;
            verdicts_due.insert(verdicts_due.size(), v);
        end
    endtask

    task automatic note_fault(input string msg);
        fails++;
        if (fails <= 10)
            $display("mismatch: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v)
            note_fault($sformatf("%s expected 0x%0h, got 0x%0h", name, want_v, got_v));
    endtask

    task automatic check_verdict();
        verdict_t want;
        if (verdicts_due.size() == 0)
        begin
            note_fault($sformatf("verdict with none due: status %0d, length %0d",
                                 result_bus.status, result_bus.matched_length));
            return;
        end
        want = verdicts_due.pop_front();
        verdicts_seen++;
        tally[result_bus.status]++;
        check_field("status", 64'(want.status), 64'(result_bus.status));
        check_field("matched_length", 64'(want.matched), 64'(result_bus.matched_length));
        check_field("big_endian", 64'(want.big), 64'(result_bus.big_endian));
        check_field("section_count", 64'(want.sections), 64'(result_bus.section_count));
        check_field("interface_count", 64'(want.ifaces), 64'(result_bus.interface_count));
        check_field("packet_count", 64'(want.packets), 64'(result_bus.packet_count));
    endtask

    task automatic add_beat(input logic [7:0] d, input bit f, input bit l, input bit fc,
                            input bit p);
        beat_t bt;
        bt.data_byte = d;
        bt.first = f;
        bt.last = l;
        bt.final_chunk = fc;
        bt.pause = p;
        pending.insert(pending.size(), bt);
        beats_total++;
    endtask

    task automatic put_word(input logic [31:0] w, input bit big);
        if (big)
        begin
            image.insert(image.size(), w[31:24]);
            image.insert(image.size(), w[23:16]);
            image.insert(image.size(), w[15:8]);
            image.insert(image.size(), w[7:0]);
        end
        else
        begin
            image.insert(image.size(), w[7:0]);
            image.insert(image.size(), w[15:8]);
            image.insert(image.size(), w[23:16]);
            image.insert(image.size(), w[31:24]);
        end
    endtask

    task automatic emit_image(input bit with_last, input bit fc, input bit p);
        int  j;
        bit  at_end;
        for (j = 0; j < image.size(); j++)
        begin
            at_end = with_last && (j == image.size() - 1);
            add_beat(image[j], j == 0, at_end, at_end ? fc : bit'($urandom_range(0, 1)),
                     p && (j == 0));
        end
        chain_items += image.size();
        captures++;
    endtask

    function automatic logic [31:0] pick_type();
        case ($urandom_range(0, 9))
            0, 1:    return T_SECTION;
            2, 3:    return T_IFACE;
            4, 5, 6: return T_EPB;
            7, 8:    return T_SPB;
            default: return T_NRB;
        endcase
    endfunction

    task automatic build_capture(input bit p);
        int          nblk;
        int          k;
        int          blen;
        int          cut;
        int          mode;
        bit          big;
        bit          nb;
        logic [31:0] btype;
        logic [31:0] wlen;
        logic [31:0] wtrail;
        fault_t      fault;
        image.delete();
        blk_marks.delete();
        big = bit'($urandom_range(0, 1));
        nblk = $urandom_range(1, 4);
        for (k = 0; k < nblk; k++)
        begin
            fault = FAULT_NONE;
            if ($urandom_range(0, 99) < 12)
                fault = fault_t'($urandom_range(1, 5));
            blk_marks.insert(blk_marks.size(), image.size());
            btype = (k == 0) ? T_SECTION : pick_type();
            if (fault == FAULT_TYPE)
                btype = $urandom_range(0, 1) ? $urandom : flip_bytes(pick_type());
            blen = (btype == T_SECTION) ? 16 + 4 * $urandom_range(0, 3)
                                        : 12 + 4 * $urandom_range(0, 4);
            if ($urandom_range(0, 49) == 0)
                blen += 4 * $urandom_range(10, 25);
            nb = (btype == T_SECTION && k != 0 && $urandom_range(0, 1)) ? !big : big;
            wlen = blen;
            if (fault == FAULT_LEN)
            begin
                case ($urandom_range(0, 4))
                    0:       wlen = $urandom_range(0, 11);
                    1:       wlen = blen + $urandom_range(1, 3);
                    2:       wlen = 32'hFFFF_FFF0;
                    3:       wlen = $urandom;
                    default: wlen = blen + 4;
                endcase
            end
            put_word(btype, big);
            put_word(wlen, (fault == FAULT_ORDER) ? nb : big);
            if (btype == T_SECTION)
                put_word((fault == FAULT_MAGIC) ? $urandom : BO_MAGIC, nb);
            repeat (blen - ((btype == T_SECTION) ? 16 : 12))
                image.insert(image.size(), 8'($urandom));
            wtrail = blen;
            if (fault == FAULT_TRAIL)
                wtrail = blen ^ (32'd4 << $urandom_range(0, 27));
            put_word(wtrail, big);
            big = nb;
        end

        mode = $urandom_range(0, 99);
        if (mode >= 55 && mode < 85)
        begin
            if ($urandom_range(0, 1))
                cut = $urandom_range(1, image.size() - 1);
            else
                cut = blk_marks[$urandom_range(0, blk_marks.size() - 1)] + $urandom_range(0, 4);
            if (cut < 1)
                cut = 1;
            if (cut >= image.size())
                cut = image.size() - 1;
            while (image.size() > cut)
                void'(image.pop_back());
        end
        else if (mode >= 95)
            repeat ($urandom_range(1, 8))
                image.insert(image.size(), 8'($urandom));
        emit_image(!(mode >= 85 && mode < 95), bit'($urandom_range(0, 1)), p);
    endtask

    task automatic build_noise();
        repeat ($urandom_range(1, 12))
            add_beat(8'($urandom), $urandom_range(0, 5) == 0, $urandom_range(0, 5) == 0,
                     bit'($urandom_range(0, 1)), 1'b0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_bus.valid <= 1'b0;
            stream_bus.data_byte <= '0;
            stream_bus.first <= 1'b0;
            stream_bus.last <= 1'b0;
            stream_bus.final_chunk <= 1'b0;
        end
        else
        begin
            if (stream_bus.valid && stream_bus.ready)
            begin
                track_beat(on_wire);
                beats_accepted++;
            end
            if (!stream_bus.valid || stream_bus.ready)
            begin
                if (pending.size() != 0 && (steady || $urandom_range(0, 99) >= 20)
                    && !(pending[0].pause && verdicts_due.size() != 0))
                begin
                    on_wire = pending.pop_front();
                    stream_bus.valid <= 1'b1;
                    stream_bus.data_byte <= on_wire.data_byte;
                    stream_bus.first <= on_wire.first;
                    stream_bus.last <= on_wire.last;
                    stream_bus.final_chunk <= on_wire.final_chunk;
                end
                else
                    stream_bus.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_bus.ready <= 1'b0;
        else
        begin
            if (result_bus.valid && result_bus.ready)
                check_verdict();
            result_bus.ready <= steady || ($urandom_range(0, 99) >= 20);
        end
    end

    initial
    begin
        int       r;
        verdict_t left;
        stream_bus.valid = 1'b0;
        stream_bus.data_byte = '0;
        stream_bus.first = 1'b0;
        stream_bus.last = 1'b0;
        stream_bus.final_chunk = 1'b0;
        result_bus.ready = 1'b0;
        forget_state();
        parsing = 1'b0;
        for (r = 0; r < 4; r++)
            tally[r] = 0;

        // stray byte, one-byte buffers, minimal big-endian section, bytes after verdict
        add_beat(8'hFF, 1'b0, 1'b1, 1'b1, 1'b0);
        add_beat(8'h00, 1'b1, 1'b1, 1'b0, 1'b0);
        add_beat(8'hFF, 1'b1, 1'b1, 1'b1, 1'b0);
        image.delete();
        put_word(T_SECTION, 1'b1);
        put_word(32'd16, 1'b1);
        put_word(BO_MAGIC, 1'b1);
        put_word(32'd16, 1'b1);
        emit_image(1'b1, 1'b1, 1'b0);
        add_beat(8'hA5, 1'b0, 1'b0, 1'b0, 1'b0);
        add_beat(8'h5A, 1'b0, 1'b1, 1'b1, 1'b0);

        while (chain_items < 1100)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
                build_noise();
            else
            begin
                if (r < 12)
                    repeat ($urandom_range(1, 3))
                        add_beat(8'($urandom), 1'b0, bit'($urandom_range(0, 1)),
                                 bit'($urandom_range(0, 1)), 1'b0);
                build_capture(captures == 6 || $urandom_range(0, 29) == 0);
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        while (beats_accepted < beats_total)
            @(posedge clk);
        while (verdicts_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        while (verdicts_due.size() != 0)
        begin
            left = verdicts_due.pop_front();
            note_fault($sformatf("verdict never came: status %0d, length %0d",
                                 left.status, left.matched));
        end

        $display("%0d byte beats driven, %0d verdicts checked", beats_accepted, verdicts_seen);
        $display("matched %0d, no match %0d, need more %0d, partial %0d, failures %0d",
                 tally[ST_MATCHED], tally[ST_NOMATCH], tally[ST_NEEDMORE], tally[ST_PARTIAL],
                 fails);
        if (fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #800000;
        $display("run stalled: %0d of %0d beats taken, %0d verdicts due",
                 beats_accepted, beats_total, verdicts_due.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
